// ===== design/life_like_automaton_step_assert.svh =====
// assertion macros for the life-like automaton step block
`ifndef LIFE_LIKE_AUTOMATON_STEP_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define LLAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LLAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LLAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LLAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/llas_pkg.sv =====
// shared types and constants of the life-like automaton step block
package llas_pkg;

	localparam logic [2:0] CFG_SURVIVE   = 3'd0;
	localparam logic [2:0] CFG_BORN      = 3'd1;
	localparam logic [2:0] CFG_NEIGHBOUR = 3'd2;
	localparam logic [2:0] CFG_ROWS      = 3'd3;
	localparam logic [2:0] CFG_COLS      = 3'd4;

	localparam logic [8:0] SURVIVE_RST   = 9'd12;
	localparam logic [8:0] BORN_RST      = 9'd8;
	localparam logic [7:0] NEIGHBOUR_RST = 8'd255;

	localparam logic [19:0] COUNT_MAX = 20'hFFFFF;

	// window bit of each neighbour position, upper-left first
	localparam logic [3:0] NB_POS [8] = '{4'd6, 4'd3, 4'd0, 4'd7, 4'd1, 4'd8, 4'd5, 4'd2};

	typedef struct packed {
		logic [8:0] survive;
		logic [8:0] born;
		logic [7:0] neighbour;
	} llas_masks_t;

	typedef struct packed {
		logic       cell_alive;
		logic       produce;
		logic       frame_done;
		logic       clear_count;
		logic [9:0] cell_row;
		logic [9:0] cell_col;
	} llas_tag_t;

	typedef struct packed {
		logic [19:0] live_count;
		logic [9:0]  cell_col;
		logic [9:0]  cell_row;
		logic        next_alive;
	} llas_result_t;

endpackage

// ===== design/life_like_automaton_step.sv =====
// top level of the streamed life-like automaton generation step
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tdata: cell_alive; tuser: frame_start
// m_axis    out  m_axis_tvalid/tready    tdata: next_alive, cell_row, cell_col, live_count;
//                                        tlast: frame_done
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// one cell per cycle unless clearing or a full queue stalls; one store read, one write a cycle
// the result of a window passes the queue, stages s1 and s2, then the output register
// after reset a clearing pass zeroes all MAX_COLS line store entries, s_axis_tready low
// configuration is always ready; a stalled m_axis fills the two-entry queue, then tready drops
module life_like_automaton_step #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] cell_alive, [7:1] zero
	input  logic        s_axis_tuser,  // [0] frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // [0] next_alive, [10:1] cell_row, [20:11] cell_col,
	                                   // [40:21] live_count, [47:41] zero
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

`include "life_like_automaton_step_assert.svh"

	localparam int CW = $clog2(MAX_COLS);
	localparam int TW = $bits(llas_pkg::llas_tag_t);
	localparam int QW = TW + CW;

	llas_pkg::llas_masks_t  masks;
	llas_pkg::llas_tag_t    f_tag;
	llas_pkg::llas_tag_t    q_tag;
	llas_pkg::llas_result_t result;
	logic [CW-1:0] f_addr;
	logic [CW-1:0] q_addr;
	logic [QW-1:0] q_head;
	logic          push;
	logic          q_ready;
	logic          q_valid;
	logic          q_pop;
	logic          busy;

	llas_front #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.cell_alive  (s_axis_tdata[0]),
		.frame_start (s_axis_tuser),
		.push_ok     (q_ready && !busy),
		.push        (push),
		.tag         (f_tag),
		.addr        (f_addr),
		.masks       (masks)
	);

	llas_queue #(
		.W (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_addr, f_tag}),
		.ready     (q_ready),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	assign q_tag  = q_head[TW-1:0];
	assign q_addr = q_head[QW-1:TW];

	llas_back #(
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.masks     (masks),
		.q_valid   (q_valid),
		.q_tag     (q_tag),
		.q_addr    (q_addr),
		.q_pop     (q_pop),
		.busy      (busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (result),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, result};

	`LLAS_ASSERT_IMP(a_clear_blocks_input, clk, arst_n, busy, !s_axis_tready)
	`LLAS_ASSERT_IMP(a_clear_pipe_empty, clk, arst_n, busy, !q_valid && !m_axis_tvalid)
	`LLAS_ASSERT_NXT(a_queue_head_kept, clk, arst_n, q_valid && !q_pop, q_valid)

endmodule

// ===== design/llas_front.sv =====
// front end: configuration registers, raster position and cell classification
module llas_front #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	localparam int RW = $clog2(MAX_ROWS),
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [10:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cell_alive,
	input  logic                    frame_start,
	input  logic                    push_ok,
	output logic                    push,
	output llas_pkg::llas_tag_t     tag,
	output logic [CW-1:0]           addr,
	output llas_pkg::llas_masks_t   masks
);

	localparam int RXW = (RW > 10) ? RW : 10;
	localparam int CXW = (CW > 10) ? CW : 10;
	localparam logic [RW-1:0] ROWS_RST = RW'(((MAX_ROWS < 1024) ? MAX_ROWS : 1024) - 1);
	localparam logic [CW-1:0] COLS_RST = CW'(((MAX_COLS < 1024) ? MAX_COLS : 1024) - 1);

	llas_pkg::llas_masks_t masks_q;
	logic [RW-1:0]  rows_m1_q;
	logic [CW-1:0]  cols_m1_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_q;
	logic           wrap_q;

	logic [RW-1:0]  rows_wr;
	logic [CW-1:0]  cols_wr;
	logic [RW-1:0]  eff_r;
	logic [CW-1:0]  eff_c;
	logic [RXW-1:0] r_x;
	logic [CXW-1:0] c_x;
	logic           col_wrap;
	logic           row_wrap;

	assign cfg_ready = 1'b1;
	assign in_ready  = push_ok;
	assign push      = in_valid && push_ok;
	assign masks     = masks_q;

	// size limits held as last index, clamped on write
	always_comb begin
		if (cfg_data < 11'd3) begin
			rows_wr = RW'(2);
		end else if (int'(cfg_data) > MAX_ROWS) begin
			rows_wr = RW'(MAX_ROWS - 1);
		end else begin
			rows_wr = RW'(cfg_data - 11'd1);
		end
		if (cfg_data < 11'd3) begin
			cols_wr = CW'(2);
		end else if (int'(cfg_data) > MAX_COLS) begin
			cols_wr = CW'(MAX_COLS - 1);
		end else begin
			cols_wr = CW'(cfg_data - 11'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q.survive   <= llas_pkg::SURVIVE_RST;
			masks_q.born      <= llas_pkg::BORN_RST;
			masks_q.neighbour <= llas_pkg::NEIGHBOUR_RST;
			rows_m1_q         <= ROWS_RST;
			cols_m1_q         <= COLS_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				llas_pkg::CFG_SURVIVE:   masks_q.survive   <= cfg_data[8:0];
				llas_pkg::CFG_BORN:      masks_q.born      <= cfg_data[8:0];
				llas_pkg::CFG_NEIGHBOUR: masks_q.neighbour <= cfg_data[7:0];
				llas_pkg::CFG_ROWS:      rows_m1_q         <= rows_wr;
				llas_pkg::CFG_COLS:      cols_m1_q         <= cols_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_r    = frame_start ? '0 : row_q;
		eff_c    = frame_start ? '0 : col_q;
		col_wrap = eff_c >= cols_m1_q;
		row_wrap = eff_r >= rows_m1_q;
		r_x      = RXW'(eff_r) - RXW'(1);
		c_x      = CXW'(eff_c) - CXW'(1);

		tag.cell_alive  = cell_alive;
		tag.produce     = (eff_r >= RW'(2)) && (eff_c >= CW'(2))
			&& (eff_r <= rows_m1_q) && (eff_c <= cols_m1_q);
		tag.frame_done  = (eff_r == rows_m1_q) && (eff_c == cols_m1_q);
		tag.clear_count = frame_start || wrap_q;
		tag.cell_row    = r_x[9:0];
		tag.cell_col    = c_x[9:0];
		addr            = eff_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			wrap_q <= 1'b0;
		end else if (push) begin
			wrap_q <= col_wrap && row_wrap;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : eff_r + RW'(1);
			end else begin
				col_q <= eff_c + CW'(1);
				row_q <= eff_r;
			end
		end
	end

endmodule

// ===== design/llas_queue.sv =====
// two-entry queue between front and back end
module llas_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         ready,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] head
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign ready = count_q != 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/llas_back.sv =====
// back end: line stores, 3x3 window, rule lookup, live count and output register
module llas_back #(
	parameter int MAX_COLS = 1024,
	localparam int CW = $clog2(MAX_COLS)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  llas_pkg::llas_masks_t  masks,
	input  logic                   q_valid,
	input  llas_pkg::llas_tag_t    q_tag,
	input  logic [CW-1:0]          q_addr,
	output logic                   q_pop,
	output logic                   busy,
	output logic                   out_valid,
	input  logic                   out_ready,
	output llas_pkg::llas_result_t out_data,
	output logic                   out_last
);

	// entry bit 1 holds row r-2, bit 0 row r-1
	logic [1:0]          store_q [MAX_COLS];
	logic [1:0]          rd_s1;
	logic [CW-1:0]       addr_s1;
	llas_pkg::llas_tag_t tag_s1;
	llas_pkg::llas_tag_t tag_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic [8:0]          window_q;
	logic [19:0]         live_q;
	logic [CW-1:0]       clr_q;
	logic                busy_q;
	logic                out_valid_q;
	llas_pkg::llas_result_t out_data_q;
	logic                out_last_q;

	logic                en;
	logic                adv_s1;
	logic                adv_s2;
	logic                load;
	logic [1:0]          wdata;
	logic                fwd;
	logic [8:0]          window_next;
	logic [3:0]          nb_cnt;
	logic                next_alive;
	logic [19:0]         live_base;
	logic [19:0]         live_next;

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	assign en     = !(valid_s2 && tag_s2.produce && out_valid_q && !out_ready);
	assign q_pop  = en && q_valid;
	assign adv_s1 = en && valid_s1;
	assign adv_s2 = en && valid_s2;
	assign load   = adv_s2 && tag_s2.produce;
	assign wdata  = {rd_s1[0], tag_s1.cell_alive};
	assign fwd    = adv_s1 && (addr_s1 == q_addr);
	assign window_next = {window_q[5:0], tag_s1.cell_alive, rd_s1[0], rd_s1[1]};

	always_ff @(posedge clk) begin
		if (busy_q) begin
			store_q[clr_q] <= 2'b00;
		end else if (adv_s1) begin
			store_q[addr_s1] <= wdata;
		end
		if (q_pop) begin
			rd_s1 <= fwd ? wdata : store_q[q_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == CW'(MAX_COLS - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_q <= clr_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tag_s1  <= q_tag;
			addr_s1 <= q_addr;
		end
		if (adv_s1) begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			window_q <= '0;
		end else if (en) begin
			valid_s1 <= q_valid;
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				window_q <= window_next;
			end
		end
	end

	always_comb begin
		nb_cnt = 4'd0;
		for (int k = 0; k < 8; k++) begin
			if (masks.neighbour[k]) begin
				nb_cnt = nb_cnt + 4'(window_q[llas_pkg::NB_POS[k]]);
			end
		end
		next_alive = window_q[4] ? masks.survive[nb_cnt] : masks.born[nb_cnt];
		live_base  = tag_s2.clear_count ? 20'd0 : live_q;
		live_next  = live_base;
		if (tag_s2.produce && next_alive && (live_base != llas_pkg::COUNT_MAX)) begin
			live_next = live_base + 20'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				live_q <= live_next;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.next_alive <= next_alive;
			out_data_q.cell_row   <= tag_s2.cell_row;
			out_data_q.cell_col   <= tag_s2.cell_col;
			out_data_q.live_count <= live_next;
			out_last_q            <= tag_s2.frame_done;
		end
	end

endmodule
